>>> hdl/mssc_pkg.sv
`timescale 1ns / 1ps
// Shared constants, action codes and glyph decode for the morphing clock renderer.
// No dependencies; imported by morphing_seven_segment_clock_renderer_unit.
package mssc_pkg;

  localparam int CELL_W   = 16;
  localparam int CELL_H   = 24;
  localparam int CLOCK_W  = 5 * CELL_W;
  localparam int IN_DATA_W = 40;

  localparam logic [7:0] FULL_ON = 8'd255;

  localparam logic [1:0] ACT_TIME  = 2'd0;
  localparam logic [1:0] ACT_PIXEL = 2'd1;
  localparam logic [1:0] ACT_FRAME = 2'd2;

  typedef logic [3:0] digit_t;

  // Segment bits a..g in bits 0..6; codes above nine draw as zero.
  function automatic logic [6:0] seg_mask(input digit_t d);
    logic [6:0] m;
    begin
      case (d)
        4'd1:    m = 7'h06;
        4'd2:    m = 7'h5B;
        4'd3:    m = 7'h4F;
        4'd4:    m = 7'h66;
        4'd5:    m = 7'h6D;
        4'd6:    m = 7'h7D;
        4'd7:    m = 7'h07;
        4'd8:    m = 7'h7F;
        4'd9:    m = 7'h6F;
        default: m = 7'h3F;
      endcase
      return m;
    end
  endfunction

  function automatic logic glyph_on(input digit_t d, input logic [3:0] x,
                                    input logic [4:0] y);
    logic [6:0] m;
    logic       full_x, right_x, left_x;
    begin
      m       = seg_mask(d);
      full_x  = (x >= 4'd2) && (x <= 4'd13);
      right_x = (x >= 4'd11) && (x <= 4'd13);
      left_x  = (x >= 4'd2) && (x <= 4'd4);
      return (m[0] && full_x  && y >= 5'd2  && y <= 5'd4)  ||
             (m[1] && right_x && y >= 5'd2  && y <= 5'd11) ||
             (m[2] && right_x && y >= 5'd12 && y <= 5'd21) ||
             (m[3] && full_x  && y >= 5'd19 && y <= 5'd21) ||
             (m[4] && left_x  && y >= 5'd12 && y <= 5'd21) ||
             (m[5] && left_x  && y >= 5'd2  && y <= 5'd11) ||
             (m[6] && full_x  && y >= 5'd11 && y <= 5'd13);
    end
  endfunction

  function automatic logic colon_on(input logic [3:0] x, input logic [4:0] y);
    logic col_x;
    begin
      col_x = (x == 4'd7) || (x == 4'd8);
      return col_x && ((y >= 5'd7 && y <= 5'd9) || (y >= 5'd14 && y <= 5'd16));
    end
  endfunction

endpackage

>>> hdl/morphing_seven_segment_clock_renderer_unit.sv
`timescale 1ns / 1ps
// Top level of the morphing seven-segment clock renderer: time state, row scan
// sequencer and a shared restoring divider. Depends on mssc_pkg.
//
// Renders HH:MM as four 16x24 seven-segment cells plus a colon cell, centered
// on a MATRIX_WIDTH x MATRIX_HEIGHT matrix, and answers one pixel request at a
// time. in_tuser carries the action: a time sample (0) or a frame end (2)
// completes when it is accepted and returns nothing. A pixel read (1) scans
// the 24 source rows of the cell from the bottom up, one row per cycle, until
// the first row that maps onto the pixel's matrix row and gives a nonzero
// value; a crossfading pixel then goes on to the shared divider that forms
// 255*n over the crossfade length. A pixel outside the clock, or on the
// blanked colon, skips the scan and goes straight to the output stage; a
// pixel that scans all 24 rows without a lit hit is answered dark; the
// slowest read hits on source row 2, the lowest lit row, and then divides.
// The row scan and the bit-per-cycle divider set the read time. in_tready is
// low while a pixel request is in work; the result waits in an output
// register so the next request can be accepted while it is still held there.
module morphing_seven_segment_clock_renderer_unit
  import mssc_pkg::*;
#(
  parameter int MATRIX_WIDTH  = 128,
  parameter int MATRIX_HEIGHT = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  // [3:0] digit_hour_tens, [7:4] digit_hour_units, [11:8] digit_minute_tens,
  // [15:12] digit_minute_units, [21:16] second_now, [28:22] pixel_x,
  // [33:29] pixel_y, [39:34] zero
  input  logic [IN_DATA_W-1:0] in_tdata,
  // [1:0] action
  input  logic [1:0]           in_tuser,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  // [7:0] intensity
  output logic [7:0]           out_tdata,
  input  logic                 cfg_wr_en,
  input  logic [7:0]           cfg_wr_data
);

  localparam int XW = $clog2(MATRIX_WIDTH + 1);
  localparam int RW = $clog2(MATRIX_HEIGHT + 1);
  localparam int X0 = (MATRIX_WIDTH - CLOCK_W) / 2;

  localparam logic [XW-1:0] X0_V    = XW'(X0);
  localparam logic [XW-1:0] X_END_V = XW'(X0 + CLOCK_W);
  localparam logic [RW-1:0] H_V     = RW'(MATRIX_HEIGHT);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DIV  = 2'd2;
  localparam logic [1:0] S_PUT  = 2'd3;

  // Matrix row reached by each source row edge: row g lands on g*H/24.
  logic [RW-1:0] row_tab [CELL_H+1];

  genvar g;
  generate
    for (g = 0; g <= CELL_H; g++) begin : g_row
      assign row_tab[g] = RW'((g * MATRIX_HEIGHT) / CELL_H);
    end
  endgenerate

  logic [1:0]    state_r,    state_nxt;
  logic [7:0]    msteps_r,   msteps_nxt;
  logic [15:0]   prev_r,     prev_nxt;
  logic [15:0]   cur_r,      cur_nxt;
  logic [5:0]    second_r,   second_nxt;
  logic [7:0]    fade_r,     fade_nxt;
  logic [4:0]    y_r,        y_nxt;
  logic [3:0]    cx_r,       cx_nxt;
  logic [RW-1:0] py_r,       py_nxt;
  logic          colon_r,    colon_nxt;
  digit_t        old_d_r,    old_d_nxt;
  digit_t        new_d_r,    new_d_nxt;
  logic [7:0]    step_r,     step_nxt;
  logic [7:0]    rem_r,      rem_nxt;
  logic [7:0]    dvd_r,      dvd_nxt;
  logic [7:0]    quo_r,      quo_nxt;
  logic [2:0]    cnt_r,      cnt_nxt;
  logic          oval_r,     oval_nxt;
  logic [7:0]    odata_r,    odata_nxt;

  logic [1:0]    act;
  logic [15:0]   in_digits;
  logic [5:0]    in_second;
  logic [XW-1:0] px_ext;
  logic [RW-1:0] py_ext;
  logic [XW-1:0] rel;
  logic [2:0]    cell_sel;
  logic          in_clock;
  logic          accept;
  logic          row_hit, a_on, b_on;
  logic          out_live, in_live;
  logic [7:0]    fade_n;
  logic [15:0]   dividend;
  logic [8:0]    trial;
  logic          trial_ge;

  assign act       = in_tuser;
  assign in_digits = {in_tdata[3:0], in_tdata[7:4], in_tdata[11:8], in_tdata[15:12]};
  assign in_second = in_tdata[21:16];
  assign px_ext    = XW'(in_tdata[28:22]);
  assign py_ext    = RW'(in_tdata[33:29]);
  assign rel       = px_ext - X0_V;
  assign cell_sel  = rel[6:4];
  assign in_clock  = (px_ext >= X0_V) && (px_ext < X_END_V) && (py_ext < H_V);

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = oval_r;
  assign out_tdata  = odata_r;

  // Row test for the scan: both edges of source row y may land on py.
  assign row_hit = (row_tab[y_r] == py_r) || (row_tab[y_r + 5'd1] == py_r);
  assign a_on    = colon_r ? colon_on(cx_r, y_r) : glyph_on(old_d_r, cx_r, y_r);
  assign b_on    = colon_r ? colon_on(cx_r, y_r) : glyph_on(new_d_r, cx_r, y_r);
  // Fade-out is nonzero until the step reaches the end; fade-in once it starts.
  assign out_live = a_on && !b_on && (step_r < msteps_r);
  assign in_live  = b_on && !a_on && (step_r != 8'd0);
  assign fade_n   = out_live ? (msteps_r - step_r) : step_r;
  assign dividend = {fade_n, 8'd0} - {8'd0, fade_n};

  // Shared divider: one restoring step a cycle, dividend bits from the top.
  assign trial    = {rem_r, dvd_r[7]};
  assign trial_ge = trial >= {1'b0, msteps_r};

  always_comb begin
    state_nxt  = state_r;
    msteps_nxt = msteps_r;
    prev_nxt   = prev_r;
    cur_nxt    = cur_r;
    second_nxt = second_r;
    fade_nxt   = fade_r;
    y_nxt      = y_r;
    cx_nxt     = cx_r;
    py_nxt     = py_r;
    colon_nxt  = colon_r;
    old_d_nxt  = old_d_r;
    new_d_nxt  = new_d_r;
    step_nxt   = step_r;
    rem_nxt    = rem_r;
    dvd_nxt    = dvd_r;
    quo_nxt    = quo_r;
    cnt_nxt    = cnt_r;
    oval_nxt   = oval_r;
    odata_nxt  = odata_r;

    // Drop the held result once the sink takes it.
    if (oval_r && out_tready) begin
      oval_nxt = 1'b0;
    end

    if (cfg_wr_en) begin
      msteps_nxt = (cfg_wr_data == 8'd0) ? 8'd1 : cfg_wr_data;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (act)
            ACT_TIME: begin
              // Only a new second is stored; a digit change restarts the fade.
              if (in_second != second_r) begin
                second_nxt = in_second;
                if (in_digits != cur_r) begin
                  prev_nxt = cur_r;
                  cur_nxt  = in_digits;
                  fade_nxt = 8'd0;
                end
              end
            end
            ACT_FRAME: begin
              if (fade_r < msteps_r) begin
                fade_nxt = fade_r + 8'd1;
              end
            end
            ACT_PIXEL: begin
              cx_nxt    = rel[3:0];
              py_nxt    = py_ext;
              y_nxt     = 5'(CELL_H - 1);
              step_nxt  = (fade_r < msteps_r) ? fade_r : msteps_r;
              colon_nxt = 1'b0;
              case (cell_sel)
                3'd0: begin
                  old_d_nxt = prev_r[15:12];
                  new_d_nxt = cur_r[15:12];
                end
                3'd1: begin
                  old_d_nxt = prev_r[11:8];
                  new_d_nxt = cur_r[11:8];
                end
                3'd3: begin
                  old_d_nxt = prev_r[7:4];
                  new_d_nxt = cur_r[7:4];
                end
                3'd4: begin
                  old_d_nxt = prev_r[3:0];
                  new_d_nxt = cur_r[3:0];
                end
                default: begin
                  colon_nxt = 1'b1;
                end
              endcase
              // Outside the clock, or the colon on an even second: answer dark.
              if (!in_clock || (cell_sel == 3'd2 && !second_r[0])) begin
                quo_nxt   = 8'd0;
                state_nxt = S_PUT;
              end else begin
                state_nxt = S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_SCAN: begin
        if (row_hit && a_on && b_on) begin
          quo_nxt   = FULL_ON;
          state_nxt = S_PUT;
        end else if (row_hit && (out_live || in_live)) begin
          // Quotient fits 8 bits, so the top byte starts as the remainder.
          rem_nxt   = dividend[15:8];
          dvd_nxt   = dividend[7:0];
          quo_nxt   = 8'd0;
          cnt_nxt   = 3'd7;
          state_nxt = S_DIV;
        end else if (y_r == 5'd0) begin
          quo_nxt   = 8'd0;
          state_nxt = S_PUT;
        end else begin
          y_nxt = y_r - 5'd1;
        end
      end

      S_DIV: begin
        rem_nxt = trial_ge ? 8'(trial - {1'b0, msteps_r}) : trial[7:0];
        quo_nxt = {quo_r[6:0], trial_ge};
        dvd_nxt = {dvd_r[6:0], 1'b0};
        cnt_nxt = cnt_r - 3'd1;
        if (cnt_r == 3'd0) begin
          state_nxt = S_PUT;
        end
      end

      S_PUT: begin
        // Hold until the output register is free.
        if (!oval_r || out_tready) begin
          oval_nxt  = 1'b1;
          odata_nxt = quo_r;
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      msteps_r <= 8'd16;
      prev_r   <= 16'd0;
      cur_r    <= 16'd0;
      second_r <= 6'd0;
      fade_r   <= 8'd16;
      oval_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      msteps_r <= msteps_nxt;
      prev_r   <= prev_nxt;
      cur_r    <= cur_nxt;
      second_r <= second_nxt;
      fade_r   <= fade_nxt;
      oval_r   <= oval_nxt;
    end
  end

  // Working and payload registers.
  always_ff @(posedge clk) begin
    y_r     <= y_nxt;
    cx_r    <= cx_nxt;
    py_r    <= py_nxt;
    colon_r <= colon_nxt;
    old_d_r <= old_d_nxt;
    new_d_r <= new_d_nxt;
    step_r  <= step_nxt;
    rem_r   <= rem_nxt;
    dvd_r   <= dvd_nxt;
    quo_r   <= quo_nxt;
    cnt_r   <= cnt_nxt;
    odata_r <= odata_nxt;
  end

endmodule

>>> tb/sv/tb_morphing_seven_segment_clock_renderer_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for the morphing seven-segment clock renderer.
// Predicts every pixel intensity from its own copy of the time and fade state;
// depends on mssc_pkg and morphing_seven_segment_clock_renderer_unit.
module tb_morphing_seven_segment_clock_renderer_unit
  import mssc_pkg::*;
();

  localparam int MAT_W    = 128;
  localparam int MAT_H    = 32;
  localparam int CLOCK_X0 = (MAT_W - CLOCK_W) / 2;
  localparam int COLON_X0 = CLOCK_X0 + 2 * CELL_W;
  // Unused action code: accepted, no state change, no result.
  localparam logic [1:0] ACT_SPARE = 2'd3;
  // Segment masks a..g, digit 0 in the lowest seven bits.
  localparam logic [69:0] SEG_ROM = {7'h6F, 7'h7F, 7'h07, 7'h7D, 7'h6D,
                                     7'h66, 7'h4F, 7'h5B, 7'h06, 7'h3F};
  localparam int PHASE_ITEMS = 120;
  localparam int TAIL_CYCLES = 60;
  localparam int LONG_STALL  = 300;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] py;
    logic [6:0] px;
    logic [5:0] sec;
    logic [3:0] mu;
    logic [3:0] mt;
    logic [3:0] hu;
    logic [3:0] ht;
  } clock_req_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_tvalid = 1'b0;
  logic                 in_tready;
  logic [IN_DATA_W-1:0] in_tdata = '0;
  logic [1:0]           in_tuser = 2'd0;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 cfg_wr_en = 1'b0;
  logic [7:0]           cfg_wr_data = 8'd0;

  // Request stream and expected intensities.
  clock_req_t  pending_requests[$];
  logic [7:0]  intensity_due[$];
  clock_req_t  cur_req;
  int          pushed_cnt = 0;
  int          accepted_cnt = 0;
  int          checked_cnt = 0;
  int          midfade_cnt = 0;
  int          error_cnt = 0;
  int          setting_cnt = 1;
  bit          calm_phase = 1'b0;

  // Predicted block state.
  logic [15:0] old_digits = 16'h0000;
  logic [15:0] shown_digits = 16'h0000;
  logic [5:0]  last_second = 6'd0;
  logic [7:0]  fade_pos = 8'd16;
  logic [7:0]  fade_len = 8'd16;

  // Driver and sink bookkeeping.
  int          src_gap = 0;
  bit          src_drain = 1'b0;
  bit          in_fire;
  int          sink_hold = 0;
  int          long_stalls = 0;

  morphing_seven_segment_clock_renderer_unit #(
    .MATRIX_WIDTH (MAT_W),
    .MATRIX_HEIGHT(MAT_H)
  ) i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Intensity prediction
  // ---------------------------------------------------------------------------
  function automatic bit span(int v, int lo, int hi);
    return v >= lo && v <= hi;
  endfunction

  // Lit test for one source pixel of a digit cell; codes above nine draw as 0.
  function automatic bit stroke_lit(logic [3:0] d, int cx, int sy);
    logic [6:0] m;
    m = SEG_ROM[(d > 4'd9 ? 0 : int'(d)) * 7 +: 7];
    return (m[0] && span(cx, 2, 13) && span(sy, 2, 4))   ||
           (m[1] && span(cx, 11, 13) && span(sy, 2, 11)) ||
           (m[2] && span(cx, 11, 13) && span(sy, 12, 21)) ||
           (m[3] && span(cx, 2, 13) && span(sy, 19, 21))  ||
           (m[4] && span(cx, 2, 4) && span(sy, 12, 21))   ||
           (m[5] && span(cx, 2, 4) && span(sy, 2, 11))    ||
           (m[6] && span(cx, 2, 13) && span(sy, 11, 13));
  endfunction

  function automatic bit dot_lit(int cx, int sy);
    return span(cx, 7, 8) && (span(sy, 7, 9) || span(sy, 14, 16));
  endfunction

  // Scan source rows bottom up; the first nonzero row that lands on py wins.
  function automatic int cell_level(bit colon, logic [3:0] od, logic [3:0] nd,
                                    int step, int m, int cx, int py);
    int  r1, r2, v;
    bit  was_on, now_on;
    for (int sy = CELL_H - 1; sy >= 0; sy--) begin
      r1 = (sy * MAT_H) / CELL_H;
      r2 = ((sy + 1) * MAT_H) / CELL_H;
      if (r1 == py || r2 == py) begin
        if (colon) begin
          was_on = dot_lit(cx, sy);
          now_on = was_on;
        end else begin
          was_on = stroke_lit(od, cx, sy);
          now_on = stroke_lit(nd, cx, sy);
        end
        if (was_on && now_on) v = int'(FULL_ON);
        else if (was_on) v = (int'(FULL_ON) * (m - step)) / m;
        else if (now_on) v = (int'(FULL_ON) * step) / m;
        else v = 0;
        if (v != 0) return v;
      end
    end
    return 0;
  endfunction

  function automatic logic [7:0] render_pixel(logic [6:0] px, logic [4:0] py);
    int rel, cell_idx, k, m, step;
    m    = (fade_len == 8'd0) ? 1 : int'(fade_len);
    step = (int'(fade_pos) < m) ? int'(fade_pos) : m;
    rel  = int'(px) - CLOCK_X0;
    if (rel < 0 || rel >= CLOCK_W) return 8'd0;
    cell_idx = rel / CELL_W;
    if (cell_idx == 2) begin
      if (!last_second[0]) return 8'd0;
      return 8'(cell_level(1'b1, 4'd0, 4'd0, 0, m, rel % CELL_W, int'(py)));
    end
    k = (cell_idx < 2) ? cell_idx : cell_idx - 1;
    return 8'(cell_level(1'b0, old_digits[12 - 4 * k +: 4], shown_digits[12 - 4 * k +: 4],
                         step, m, rel % CELL_W, int'(py)));
  endfunction

  // Advance the predicted state by one accepted request.
  task automatic apply_request(clock_req_t r);
    logic [15:0] d;
    logic [7:0]  v;
    case (r.action)
      ACT_TIME: begin
        if (r.sec != last_second) begin
          d = {r.ht, r.hu, r.mt, r.mu};
          last_second = r.sec;
          if (d != shown_digits) begin
            old_digits   = shown_digits;
            shown_digits = d;
            fade_pos     = 8'd0;
          end
        end
      end
      ACT_PIXEL: begin
        v = render_pixel(r.px, r.py);
        if (v != 8'd0 && v != FULL_ON) midfade_cnt++;
        intensity_due.push_back(v);
      end
      ACT_FRAME: begin
        if (fade_pos < fade_len) fade_pos = fade_pos + 8'd1;
      end
      default: ;
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // Request construction
  // ---------------------------------------------------------------------------
  // Mostly short gaps, now and then a long one; none at all in a calm phase.
  function automatic int gap_len();
    int p;
    if (calm_phase) return 0;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Start from random bits so unused fields toggle too.
  function automatic clock_req_t noise_req(logic [1:0] act);
    clock_req_t  r;
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    r = raw[35:0];
    r.action = act;
    return r;
  endfunction

  function automatic logic [3:0] rand_digit();
    if ($urandom_range(0, 19) == 0) return 4'($urandom_range(10, 15));
    return 4'($urandom_range(0, 9));
  endfunction

  task automatic offer(clock_req_t r);
    pending_requests.push_back(r);
    pushed_cnt++;
  endtask

  task automatic offer_time(int ht, int hu, int mt, int mu, int sec);
    clock_req_t r;
    r = noise_req(ACT_TIME);
    r.ht = 4'(ht); r.hu = 4'(hu); r.mt = 4'(mt); r.mu = 4'(mu); r.sec = 6'(sec);
    offer(r);
  endtask

  task automatic offer_pixel(int x, int y);
    clock_req_t r;
    r = noise_req(ACT_PIXEL);
    r.px = 7'(x);
    r.py = 5'(y);
    offer(r);
  endtask

  // Aim most reads at the clock area, where the glyphs live.
  task automatic offer_rand_pixel();
    if ($urandom_range(0, 3) != 0)
      offer_pixel(CLOCK_X0 + $urandom_range(0, CLOCK_W - 1), $urandom_range(0, 31));
    else
      offer_pixel($urandom_range(0, 127), $urandom_range(0, 31));
  endtask

  // Random mix for one setting: mostly a time change followed by a fade with
  // reads between frames; the rest is stray reads, spare codes and stale times.
  task automatic fill_phase(int target, ref int gen_sec);
    int stop, p, n, reads;
    stop = pushed_cnt + target;
    while (pushed_cnt < stop) begin
      p = $urandom_range(0, 99);
      if (p < 70) begin
        if ($urandom_range(0, 4) == 0) gen_sec = $urandom_range(0, 63);
        else gen_sec = (gen_sec + 1) % 60;
        offer_time(rand_digit(), rand_digit(), rand_digit(), rand_digit(), gen_sec);
        // Run a fade to its end only when it fits in what is left of the phase.
        if ($urandom_range(0, 14) == 0 && stop - pushed_cnt > int'(fade_len) + 2)
          n = int'(fade_len) + 2;
        else n = $urandom_range(0, (fade_len < 8 ? int'(fade_len) : 8) + 1);
        for (int f = 0; f < n; f++) begin
          reads = (n > 16) ? ($urandom_range(0, 15) == 0 ? 1 : 0) : $urandom_range(0, 3);
          for (int i = 0; i < reads; i++) offer_rand_pixel();
          offer(noise_req(ACT_FRAME));
        end
        offer_rand_pixel();
      end else if (p < 85) begin
        offer_rand_pixel();
      end else if (p < 92) begin
        offer(noise_req(ACT_SPARE));
      end else begin
        // Same second with other digits: must be ignored.
        offer_time(rand_digit(), rand_digit(), rand_digit(), rand_digit(), gen_sec);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued requests, predict on acceptance
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      in_fire = in_tvalid && in_tready;
      if (in_fire) begin
        apply_request(cur_req);
        accepted_cnt++;
        // Pause now and then until every outstanding read has been answered.
        if (accepted_cnt % 150 == 0) src_drain = 1'b1;
      end
      if (src_drain && intensity_due.size() == 0) src_drain = 1'b0;
      if (in_tvalid && !in_fire) begin
        // Hold the request until the block takes it.
      end else if (src_gap > 0) begin
        src_gap--;
        in_tvalid <= 1'b0;
      end else if (!src_drain && pending_requests.size() > 0) begin
        cur_req = pending_requests.pop_front();
        in_tuser  <= cur_req.action;
        in_tdata  <= {6'b0, cur_req.py, cur_req.px, cur_req.sec,
                      cur_req.mu, cur_req.mt, cur_req.hu, cur_req.ht};
        in_tvalid <= 1'b1;
        src_gap = gap_len();
      end else begin
        in_tvalid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sink: random back-pressure and result check
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (intensity_due.size() == 0) begin
          $error("unexpected result: intensity %0d with nothing outstanding", out_tdata);
          error_cnt++;
        end else begin
          if (out_tdata !== intensity_due[0]) begin
            $error("intensity mismatch: expected %0d, actual %0d",
                   intensity_due[0], out_tdata);
            error_cnt++;
          end
          void'(intensity_due.pop_front());
          checked_cnt++;
          // Hold off for a long stretch twice so the block backs up its input.
          if (checked_cnt == 40 || checked_cnt == 250) begin
            sink_hold = LONG_STALL;
            long_stalls++;
          end
        end
      end
      if (sink_hold > 0) begin
        sink_hold--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
        sink_hold = gap_len();
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Sequence: reset, directed checks, then one random phase per fade length
  // ---------------------------------------------------------------------------
  task automatic wait_idle();
    while (accepted_cnt != pushed_cnt || intensity_due.size() != 0) @(negedge clk);
    // Time samples and frame ends leave nothing to wait for; let them settle.
    repeat (TAIL_CYCLES) @(negedge clk);
  endtask

  task automatic write_fade_len(logic [7:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    fade_len = (v == 8'd0) ? 8'd1 : v;
    setting_cnt++;
  endtask

  initial begin
    int          gen_sec;
    logic [7:0]  settings[6];
    settings = '{8'd1, 8'd255, 8'd0, 8'd2, 8'd128, 8'd0};
    settings[5] = 8'($urandom_range(3, 254));
    gen_sec = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part at the reset fade length: all-zero digits, fade complete.
    offer_pixel(CLOCK_X0 + 5, 2);          // shared stroke at full brightness
    offer_pixel(0, 0);                     // left of the clock
    offer_pixel(127, 31);                  // far corner
    offer_pixel(COLON_X0 + 7, 9);          // colon blanked on an even second
    offer_time(1, 2, 3, 4, 1);             // new digits restart the fade
    offer_pixel(COLON_X0 + 7, 9);          // colon lit on an odd second
    offer_pixel(CLOCK_X0 + CELL_W + 5, 16); // fading in, still dark at step 0
    offer_pixel(CLOCK_X0 + 5, 2);          // fading out, still full
    repeat (4) offer(noise_req(ACT_FRAME));
    offer_pixel(CLOCK_X0 + CELL_W + 5, 16);
    offer_pixel(CLOCK_X0 + 5, 2);
    offer_time(9, 9, 9, 9, 1);             // same second: ignored
    offer_time(15, 10, 12, 8, 63);         // digits above nine, second above 59
    offer(noise_req(ACT_SPARE));
    offer_pixel(CLOCK_X0 - 1, 16);
    offer_pixel(CLOCK_X0 + 2, 3);
    offer_pixel(CLOCK_X0 + CLOCK_W - 1, 20);
    offer_pixel(CLOCK_X0 + CLOCK_W, 20);
    offer_time(15, 10, 12, 8, 62);         // new second, same digits
    offer_pixel(COLON_X0 + 8, 21);
    offer_pixel(CLOCK_X0 + 3 * CELL_W + 12, 31);
    gen_sec = 62;
    fill_phase(PHASE_ITEMS, gen_sec);
    wait_idle();

    foreach (settings[i]) begin
      write_fade_len(settings[i]);
      @(negedge clk);
      calm_phase = (i == 1);
      fill_phase(PHASE_ITEMS, gen_sec);
      wait_idle();
    end

    $display("Ran %0d requests across %0d fade lengths with %0d long output stalls.",
             accepted_cnt, setting_cnt, long_stalls);
    $display("Checked %0d pixel intensities, %0d of them partway through a fade.",
             checked_cnt, midfade_cnt);
    if (error_cnt == 0 && intensity_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog far beyond the slowest legal run.
  initial begin
    #20ms;
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

>>> filelist.f
hdl/mssc_pkg.sv
hdl/morphing_seven_segment_clock_renderer_unit.sv
tb/sv/tb_morphing_seven_segment_clock_renderer_unit.sv
